// ===== sv/colored_graph_path_engine_core_defines.svh =====
// Assertion macros used by the checker file cgpe_chk.sv.
`ifndef COLORED_GRAPH_PATH_ENGINE_CORE_DEFINES_SVH
`define COLORED_GRAPH_PATH_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define CGPE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CGPE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cgpe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cgpe_pkg;

  localparam int MAX_NODES = 128;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int CFG_W     = 8;
  localparam int DIST_W    = 8;
  localparam int PRED_W    = 8;
  localparam int COL_W     = 2;
  localparam int NST_W     = 1 + DIST_W + PRED_W;

  localparam logic [CFG_W-1:0]  CFG_RESET = 8'd128;
  localparam logic [DIST_W-1:0] DIST_INF  = 8'hFF;
  localparam logic [DIST_W-1:0] DIST_MAX  = 8'hFE;
  localparam logic [PRED_W-1:0] PRED_NONE = 8'hFF;
  localparam logic [COL_W-1:0]  COL_EMPTY = 2'd0;

  typedef enum logic [2:0] {
    MODE_CONNECT = 3'd0,
    MODE_COLOUR  = 3'd1,
    MODE_PATH    = 3'd2,
    MODE_REACH   = 3'd3,
    MODE_PRED    = 3'd4
  } mode_t;

  typedef struct packed {
    logic                 adj_we;
    logic [NODE_W-1:0]    adj_wa;
    logic [MAX_NODES-1:0] adj_wd;
    logic [NODE_W-1:0]    adj_ra;
    logic                 col_we;
    logic [NODE_W-1:0]    col_wa;
    logic [COL_W-1:0]     col_wd;
    logic [NODE_W-1:0]    col_ra;
    logic                 nst_we;
    logic [NODE_W-1:0]    nst_wa;
    logic [NST_W-1:0]     nst_wd;
    logic [NODE_W-1:0]    nst_ra;
    logic                 mrk_we;
    logic [NODE_W-1:0]    mrk_wa;
    logic                 mrk_wd;
    logic [NODE_W-1:0]    mrk_ra;
    logic                 que_we;
    logic [NODE_W-1:0]    que_wa;
    logic [NODE_W-1:0]    que_wd;
    logic [NODE_W-1:0]    que_ra;
  } mem_req_t;

  typedef struct packed {
    logic [MAX_NODES-1:0] adj_rd;
    logic [COL_W-1:0]     col_rd;
    logic [NST_W-1:0]     nst_rd;
    logic                 mrk_rd;
    logic [NODE_W-1:0]    que_rd;
  } mem_rsp_t;

endpackage
`default_nettype wire

// ===== sv/cgpe_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cgpe_mem import cgpe_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [COL_W-1:0]     col_mem [MAX_NODES];
  logic [NST_W-1:0]     nst_mem [MAX_NODES];
  logic                 mrk_mem [MAX_NODES];
  logic [NODE_W-1:0]    que_mem [MAX_NODES];

  logic [MAX_NODES-1:0] adj_rd_r;
  logic [COL_W-1:0]     col_rd_r;
  logic [NST_W-1:0]     nst_rd_r;
  logic                 mrk_rd_r;
  logic [NODE_W-1:0]    que_rd_r;

  always_ff @(posedge clk) begin
    if (req.adj_we) begin
      adj_mem[req.adj_wa] <= req.adj_wd;
    end
    if (req.col_we) begin
      col_mem[req.col_wa] <= req.col_wd;
    end
    if (req.nst_we) begin
      nst_mem[req.nst_wa] <= req.nst_wd;
    end
    if (req.mrk_we) begin
      mrk_mem[req.mrk_wa] <= req.mrk_wd;
    end
    if (req.que_we) begin
      que_mem[req.que_wa] <= req.que_wd;
    end
    adj_rd_r <= adj_mem[req.adj_ra];
    col_rd_r <= col_mem[req.col_ra];
    nst_rd_r <= nst_mem[req.nst_ra];
    mrk_rd_r <= mrk_mem[req.mrk_ra];
    que_rd_r <= que_mem[req.que_ra];
  end

  assign rsp.adj_rd = adj_rd_r;
  assign rsp.col_rd = col_rd_r;
  assign rsp.nst_rd = nst_rd_r;
  assign rsp.mrk_rd = mrk_rd_r;
  assign rsp.que_rd = que_rd_r;

endmodule
`default_nettype wire

// ===== sv/cgpe_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cgpe_alu import cgpe_pkg::*; (
  input  logic [DIST_W-1:0] op_a,
  input  logic [DIST_W-1:0] op_b,
  input  logic              inc,
  input  logic              sat,
  output logic [DIST_W-1:0] sum,
  output logic              lt
);

  logic [DIST_W:0] sum_w;

  always_comb begin
    sum_w = {1'b0, op_a} + {{DIST_W{1'b0}}, inc};
    if (sat && (sum_w >= {1'b0, DIST_INF})) begin
      sum = DIST_MAX;
    end else begin
      sum = sum_w[DIST_W-1:0];
    end
    lt = (sum < op_b);
  end

endmodule
`default_nettype wire

// ===== sv/cgpe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cgpe_ctrl import cgpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_mode,
  input  logic [NODE_W-1:0]        in_node_a,
  input  logic [NODE_W-1:0]        in_node_b,
  input  logic [COL_W-1:0]         in_color,
  input  logic [CFG_W-1:0]         in_real_count,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  output logic [DIST_W-1:0]        out_distance,
  output logic                     out_reachable,
  output logic signed [PRED_W-1:0] out_predecessor,
  output mem_req_t                 mreq,
  input  mem_rsp_t                 mrsp
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CON_RA, S_CON_WA, S_CON_RB, S_CON_WB, S_COL,
    S_PRD_RD, S_PRD_OUT, S_P_INIT, S_P_SCAN, S_P_MARK, S_P_RELAX,
    S_P_FIN_RD, S_P_FIN, S_R_CS, S_R_CT, S_R_CHK, S_R_CLR, S_R_SEED,
    S_R_POP, S_R_CUR, S_R_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    node_count_r, node_count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                pv_r, pv_nxt;
  logic [NODE_W-1:0]   pidx_r, pidx_nxt;
  logic [NODE_W-1:0]   a_r, a_nxt;
  logic [NODE_W-1:0]   b_r, b_nxt;
  logic [COL_W-1:0]    qc_r, qc_nxt;
  logic [CFG_W-1:0]    real_r, real_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic                found_r, found_nxt;
  logic [DIST_W-1:0]   best_r, best_nxt;
  logic [PRED_W-1:0]   bpred_r, bpred_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic [CNT_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    tail_r, tail_nxt;
  logic [COL_W-1:0]    cs_r, cs_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_dist_r, out_dist_nxt;
  logic                out_reach_r, out_reach_nxt;
  logic [PRED_W-1:0]   out_pred_r, out_pred_nxt;

  logic [NODE_W-1:0]   idx_lo;
  logic                issue;
  logic                stream_end;
  logic                nst_vis;
  logic [DIST_W-1:0]   nst_dist;
  logic [PRED_W-1:0]   nst_pred;
  logic                relax_ok;
  logic [CNT_W-1:0]    n_cap;
  logic [DIST_W-1:0]   alu_a, alu_b, alu_sum;
  logic                alu_inc, alu_sat, alu_lt;

  cgpe_alu u_alu (
    .op_a (alu_a),
    .op_b (alu_b),
    .inc  (alu_inc),
    .sat  (alu_sat),
    .sum  (alu_sum),
    .lt   (alu_lt)
  );

  assign idx_lo     = idx_r[NODE_W-1:0];
  assign issue      = (idx_r < n_r);
  assign stream_end = !issue && !pv_r;
  assign nst_vis    = mrsp.nst_rd[NST_W-1];
  assign nst_dist   = mrsp.nst_rd[PRED_W +: DIST_W];
  assign nst_pred   = mrsp.nst_rd[PRED_W-1:0];
  assign n_cap      = (32'(node_count_r) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(node_count_r);
  assign relax_ok   = (pidx_r != cur_r) && mrsp.adj_rd[pidx_r]
                      && ((32'(pidx_r) < 32'(real_r)) || (pidx_r == b_r))
                      && ((mrsp.col_rd == COL_EMPTY) || (mrsp.col_rd == qc_r));

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = cfg_wr_en ? cfg_wr_data : node_count_r;
    idx_nxt        = idx_r;
    pv_nxt         = pv_r;
    pidx_nxt       = pidx_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    qc_nxt         = qc_r;
    real_nxt       = real_r;
    n_nxt          = n_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    bpred_nxt      = bpred_r;
    cur_nxt        = cur_r;
    left_nxt       = left_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cs_nxt         = cs_r;
    out_valid_nxt  = 1'b0;
    out_dist_nxt   = out_dist_r;
    out_reach_nxt  = out_reach_r;
    out_pred_nxt   = out_pred_r;

    mreq        = '0;
    mreq.adj_ra = cur_r;
    mreq.adj_wa = a_r;
    mreq.col_ra = idx_lo;
    mreq.col_wa = idx_lo;
    mreq.nst_ra = idx_lo;
    mreq.nst_wa = pidx_r;
    mreq.mrk_ra = idx_lo;
    mreq.mrk_wa = pidx_r;
    mreq.que_ra = head_r[NODE_W-1:0];
    mreq.que_wa = tail_r[NODE_W-1:0];
    mreq.que_wd = pidx_r;

    alu_a   = nst_dist;
    alu_b   = best_r;
    alu_inc = 1'b0;
    alu_sat = 1'b0;

    if ((state_r == S_P_SCAN) || (state_r == S_P_RELAX) || (state_r == S_R_SCAN)) begin
      idx_nxt  = issue ? (idx_r + CNT_W'(1)) : idx_r;
      pv_nxt   = issue;
      pidx_nxt = idx_lo;
    end

    unique case (state_r)
      S_CLR: begin
        mreq.adj_we = 1'b1;
        mreq.adj_wa = idx_lo;
        mreq.col_we = 1'b1;
        mreq.nst_we = 1'b1;
        mreq.nst_wa = idx_lo;
        mreq.nst_wd = {1'b0, DIST_INF, PRED_NONE};
        idx_nxt     = idx_r + CNT_W'(1);
        if (idx_r == CNT_W'(MAX_NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          a_nxt    = in_node_a;
          b_nxt    = in_node_b;
          qc_nxt   = in_color;
          real_nxt = in_real_count;
          n_nxt    = n_cap;
          idx_nxt  = '0;
          pv_nxt   = 1'b0;
          priority case (in_mode)
            MODE_CONNECT: state_nxt = S_CON_RA;
            MODE_COLOUR:  state_nxt = S_COL;
            MODE_PATH:    state_nxt = S_P_INIT;
            MODE_REACH:   state_nxt = S_R_CS;
            MODE_PRED:    state_nxt = S_PRD_RD;
            default: begin
              out_valid_nxt = 1'b1;
              out_dist_nxt  = '0;
              out_reach_nxt = 1'b0;
              out_pred_nxt  = '0;
            end
          endcase
        end
      end
      S_CON_RA: begin
        mreq.adj_ra = a_r;
        state_nxt   = S_CON_WA;
      end
      S_CON_WA: begin
        mreq.adj_we = 1'b1;
        mreq.adj_wa = a_r;
        mreq.adj_wd = mrsp.adj_rd | (MAX_NODES'(1) << b_r);
        state_nxt   = S_CON_RB;
      end
      S_CON_RB: begin
        mreq.adj_ra = b_r;
        state_nxt   = S_CON_WB;
      end
      S_CON_WB: begin
        mreq.adj_we   = 1'b1;
        mreq.adj_wa   = b_r;
        mreq.adj_wd   = mrsp.adj_rd | (MAX_NODES'(1) << a_r);
        out_valid_nxt = 1'b1;
        out_dist_nxt  = '0;
        out_reach_nxt = 1'b0;
        out_pred_nxt  = '0;
        state_nxt     = S_IDLE;
      end
      S_COL: begin
        mreq.col_we   = 1'b1;
        mreq.col_wa   = a_r;
        mreq.col_wd   = qc_r;
        out_valid_nxt = 1'b1;
        out_dist_nxt  = '0;
        out_reach_nxt = 1'b0;
        out_pred_nxt  = '0;
        state_nxt     = S_IDLE;
      end
      S_PRD_RD: begin
        mreq.nst_ra = a_r;
        state_nxt   = S_PRD_OUT;
      end
      S_PRD_OUT: begin
        out_valid_nxt = 1'b1;
        out_dist_nxt  = '0;
        out_reach_nxt = 1'b0;
        out_pred_nxt  = nst_pred;
        state_nxt     = S_IDLE;
      end
      S_P_INIT: begin
        mreq.nst_we = 1'b1;
        mreq.nst_wa = idx_lo;
        mreq.nst_wd = {1'b0, DIST_INF, PRED_NONE};
        if ((idx_lo == a_r) && (CNT_W'(a_r) < n_r)) begin
          mreq.nst_wd = {1'b0, {DIST_W{1'b0}}, PRED_NONE};
        end
        idx_nxt = idx_r + CNT_W'(1);
        if (idx_r == CNT_W'(MAX_NODES - 1)) begin
          left_nxt  = n_r;
          idx_nxt   = '0;
          pv_nxt    = 1'b0;
          found_nxt = 1'b0;
          state_nxt = (n_r == '0) ? S_P_FIN_RD : S_P_SCAN;
        end
      end
      S_P_SCAN: begin
        if (pv_r && !nst_vis && (!found_r || alu_lt)) begin
          found_nxt = 1'b1;
          best_nxt  = nst_dist;
          bpred_nxt = nst_pred;
          cur_nxt   = pidx_r;
        end
        if (stream_end) begin
          state_nxt = found_r ? S_P_MARK : S_P_FIN_RD;
        end
      end
      S_P_MARK: begin
        mreq.nst_we = 1'b1;
        mreq.nst_wa = cur_r;
        mreq.nst_wd = {1'b1, best_r, bpred_r};
        left_nxt    = left_r - CNT_W'(1);
        idx_nxt     = '0;
        pv_nxt      = 1'b0;
        if ((cur_r == b_r) || (best_r == DIST_INF)) begin
          state_nxt = S_P_FIN_RD;
        end else begin
          state_nxt = S_P_RELAX;
        end
      end
      S_P_RELAX: begin
        alu_a   = best_r;
        alu_b   = nst_dist;
        alu_inc = (mrsp.col_rd == COL_EMPTY);
        alu_sat = 1'b1;
        if (pv_r && relax_ok && alu_lt) begin
          mreq.nst_we = 1'b1;
          mreq.nst_wd = {nst_vis, alu_sum, PRED_W'(cur_r)};
        end
        if (stream_end) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (left_r == '0) ? S_P_FIN_RD : S_P_SCAN;
        end
      end
      S_P_FIN_RD: begin
        mreq.nst_ra = b_r;
        state_nxt   = S_P_FIN;
      end
      S_P_FIN: begin
        out_valid_nxt = 1'b1;
        out_dist_nxt  = (CNT_W'(b_r) >= n_r) ? DIST_INF : nst_dist;
        out_reach_nxt = 1'b0;
        out_pred_nxt  = '0;
        state_nxt     = S_IDLE;
      end
      S_R_CS: begin
        mreq.col_ra = a_r;
        if ((CNT_W'(a_r) >= n_r) || (CNT_W'(b_r) >= n_r)) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = '0;
          out_reach_nxt = 1'b0;
          out_pred_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_R_CT;
        end
      end
      S_R_CT: begin
        mreq.col_ra = b_r;
        cs_nxt      = mrsp.col_rd;
        state_nxt   = S_R_CHK;
      end
      S_R_CHK: begin
        if ((cs_r != mrsp.col_rd) && (mrsp.col_rd != qc_r)) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = '0;
          out_reach_nxt = 1'b0;
          out_pred_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_R_CLR;
        end
      end
      S_R_CLR: begin
        mreq.mrk_we = 1'b1;
        mreq.mrk_wa = idx_lo;
        mreq.mrk_wd = 1'b0;
        idx_nxt     = idx_r + CNT_W'(1);
        if (idx_r == (n_r - CNT_W'(1))) begin
          state_nxt = S_R_SEED;
        end
      end
      S_R_SEED: begin
        mreq.que_we = 1'b1;
        mreq.que_wa = '0;
        mreq.que_wd = a_r;
        mreq.mrk_we = 1'b1;
        mreq.mrk_wa = a_r;
        mreq.mrk_wd = 1'b1;
        head_nxt    = '0;
        tail_nxt    = CNT_W'(1);
        state_nxt   = S_R_POP;
      end
      S_R_POP: begin
        if (head_r < tail_r) begin
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = S_R_CUR;
        end else begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = '0;
          out_reach_nxt = 1'b0;
          out_pred_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_R_CUR: begin
        mreq.adj_ra = mrsp.que_rd;
        cur_nxt     = mrsp.que_rd;
        if (mrsp.que_rd == b_r) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = '0;
          out_reach_nxt = 1'b1;
          out_pred_nxt  = '0;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = '0;
          pv_nxt    = 1'b0;
          state_nxt = S_R_SCAN;
        end
      end
      S_R_SCAN: begin
        if (pv_r && mrsp.adj_rd[pidx_r] && (mrsp.col_rd == qc_r) && !mrsp.mrk_rd) begin
          mreq.mrk_we = 1'b1;
          mreq.mrk_wd = 1'b1;
          if (32'(tail_r) < MAX_NODES) begin
            mreq.que_we = 1'b1;
            tail_nxt    = tail_r + CNT_W'(1);
          end
        end
        if (stream_end) begin
          state_nxt = S_R_POP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      node_count_r <= CFG_RESET;
      idx_r        <= '0;
      pv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      idx_r        <= idx_nxt;
      pv_r         <= pv_nxt;
      out_valid_r  <= out_valid_nxt;
      pidx_r       <= pidx_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      qc_r         <= qc_nxt;
      real_r       <= real_nxt;
      n_r          <= n_nxt;
      found_r      <= found_nxt;
      best_r       <= best_nxt;
      bpred_r      <= bpred_nxt;
      cur_r        <= cur_nxt;
      left_r       <= left_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cs_r         <= cs_nxt;
      out_dist_r   <= out_dist_nxt;
      out_reach_r  <= out_reach_nxt;
      out_pred_r   <= out_pred_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_distance    = out_dist_r;
  assign out_reachable   = out_reach_r;
  assign out_predecessor = out_pred_r;

endmodule
`default_nettype wire

// ===== sv/colored_graph_path_engine_core.sv =====
// Channel   Beat marker          Payload
// input     start && !busy       in_mode, in_node_a, in_node_b, in_color, in_real_count
// result    out_valid (1 cycle)  out_distance, out_reachable, out_predecessor
// config    cfg_wr_en            cfg_wr_data (node count)
//
// After reset, with busy high, it clears the adjacency, colour and node state rows, one a cycle.
// Connect reads and updates the row of each end node in turn; unused modes give an all-zero result.
// A path query first resets all 128 node state rows, then per settled node it scans the
// node state memory, one read per cycle, for the nearest unvisited node and to relax its edges.
// A reachability query first clears the n active marks, then scans all n nodes per node dequeued.
// Each result is shown for one cycle; busy falls in that same cycle.
`timescale 1ns / 1ps
`default_nettype none
module colored_graph_path_engine_core import cgpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_mode,
  input  logic [NODE_W-1:0]        in_node_a,
  input  logic [NODE_W-1:0]        in_node_b,
  input  logic [COL_W-1:0]         in_color,
  input  logic [CFG_W-1:0]         in_real_count,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  output logic                     out_valid,
  output logic [DIST_W-1:0]        out_distance,
  output logic                     out_reachable,
  output logic signed [PRED_W-1:0] out_predecessor
);

  mem_req_t mreq;
  mem_rsp_t mrsp;

  cgpe_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_node_a       (in_node_a),
    .in_node_b       (in_node_b),
    .in_color        (in_color),
    .in_real_count   (in_real_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_distance    (out_distance),
    .out_reachable   (out_reachable),
    .out_predecessor (out_predecessor),
    .mreq            (mreq),
    .mrsp            (mrsp)
  );

  cgpe_mem u_mem (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

endmodule
`default_nettype wire

// ===== sv/cgpe_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "colored_graph_path_engine_core_defines.svh"
module cgpe_chk import cgpe_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic [DIST_W-1:0]        out_distance,
  input logic                     out_reachable,
  input logic signed [PRED_W-1:0] out_predecessor
);

  `CGPE_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy || out_valid, "accepted beat neither busy nor answered")
  `CGPE_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy, "result shown while busy")
  `CGPE_ASSERT_NXT(a_no_spurious, clk, rst_n, !busy && !start, !out_valid, "result without a beat")
  `CGPE_ASSERT_IMP(a_reach_alone, clk, rst_n, out_valid && out_reachable, out_distance == 8'd0 && out_predecessor == 8'sd0, "reach result with other fields set")
  `CGPE_ASSERT_IMP(a_pred_alone, clk, rst_n, out_valid && out_predecessor != 8'sd0, out_distance == 8'd0 && !out_reachable, "predecessor result with other fields set")

endmodule

bind colored_graph_path_engine_core cgpe_chk u_cgpe_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_distance    (out_distance),
  .out_reachable   (out_reachable),
  .out_predecessor (out_predecessor)
);
`default_nettype wire

// ===== sim/cgpe_checker.sv =====
`timescale 1ns / 1ps
module cgpe_checker import cgpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [2:0]               in_mode,
  input  logic [NODE_W-1:0]        in_node_a,
  input  logic [NODE_W-1:0]        in_node_b,
  input  logic [COL_W-1:0]         in_color,
  input  logic [CFG_W-1:0]         in_real_count,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic                     out_valid,
  input  logic [DIST_W-1:0]        out_distance,
  input  logic                     out_reachable,
  input  logic signed [PRED_W-1:0] out_predecessor,
  output int                       fails,
  output int                       pending
);

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              reach;
    logic [PRED_W-1:0] pred;
  } answer_t;

  logic [MAX_NODES-1:0] adj_row [MAX_NODES];
  logic [COL_W-1:0]     colour_of [MAX_NODES];
  logic [PRED_W-1:0]    pred_of [MAX_NODES];
  int                   node_cnt;
  answer_t              answers [$];

  initial fails = 0;
  assign pending = answers.size();

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    fails++;
  endtask

  function automatic int active_n();
    return (node_cnt < MAX_NODES) ? node_cnt : MAX_NODES;
  endfunction

  function automatic logic [DIST_W-1:0] shortest_cost(int s, int t, int lim, int qc);
    int n, i, cur, left, cost, nd;
    bit found;
    logic [DIST_W-1:0] dist_of [MAX_NODES];
    bit seen [MAX_NODES];
    n = active_n();
    for (i = 0; i < MAX_NODES; i++) begin
      dist_of[i] = DIST_INF;
      pred_of[i] = PRED_NONE;
      seen[i] = 0;
    end
    if (s < n) dist_of[s] = 0;
    for (left = n; left > 0; left--) begin
      cur = 0;
      found = 0;
      for (i = 0; i < n; i++) begin
        if (!seen[i] && (!found || dist_of[i] < dist_of[cur])) begin
          cur = i;
          found = 1;
        end
      end
      if (!found) break;
      seen[cur] = 1;
      if (cur == t || dist_of[cur] == DIST_INF) break;
      for (i = 0; i < n; i++) begin
        if (i == cur || !adj_row[i][cur]) continue;
        if (!(i < lim || i == t)) continue;
        if (colour_of[i] == COL_EMPTY) cost = 1;
        else if (colour_of[i] == qc) cost = 0;
        else continue;
        nd = dist_of[cur] + cost;
        if (nd >= DIST_INF) nd = DIST_MAX;
        if (nd < dist_of[i]) begin
          dist_of[i] = nd;
          pred_of[i] = cur;
        end
      end
    end
    return (t >= n) ? DIST_INF : dist_of[t];
  endfunction

  function automatic logic same_colour_reach(int s, int t, int qc);
    int n, i, cur;
    int frontier [$];
    bit mark [MAX_NODES];
    n = active_n();
    if (s >= n || t >= n) return 0;
    if (colour_of[s] != colour_of[t] && colour_of[t] != qc) return 0;
    for (i = 0; i < MAX_NODES; i++) mark[i] = 0;
    frontier.push_back(s);
    mark[s] = 1;
    while (frontier.size() > 0) begin
      cur = frontier.pop_front();
      if (cur == t) return 1;
      for (i = 0; i < n; i++) begin
        if (adj_row[i][cur] && colour_of[i] == qc && !mark[i]) begin
          mark[i] = 1;
          frontier.push_back(i);
        end
      end
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    answer_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        adj_row[i] = '0;
        colour_of[i] = COL_EMPTY;
        pred_of[i] = PRED_NONE;
      end
      node_cnt = CFG_RESET;
      answers.delete();
    end else begin
      if (out_valid) begin
        if (answers.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          want = answers.pop_front();
          if (out_distance !== want.distance) report("distance", out_distance, want.distance);
          if (out_reachable !== want.reach) report("reachable", out_reachable, want.reach);
          if (out_predecessor !== want.pred)
            report("predecessor", $signed(out_predecessor), $signed(want.pred));
        end
      end
      if (cfg_wr_en) node_cnt = cfg_wr_data;
      if (start && !busy) begin
        got = '{distance: '0, reach: 1'b0, pred: '0};
        case (in_mode)
          MODE_CONNECT: begin
            adj_row[in_node_a][in_node_b] = 1'b1;
            adj_row[in_node_b][in_node_a] = 1'b1;
          end
          MODE_COLOUR: colour_of[in_node_a] = in_color;
          MODE_PATH: got.distance = shortest_cost(in_node_a, in_node_b, in_real_count, in_color);
          MODE_REACH: got.reach = same_colour_reach(in_node_a, in_node_b, in_color);
          MODE_PRED: got.pred = pred_of[in_node_a];
          default: ;
        endcase
        answers.push_back(got);
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import cgpe_pkg::*;

  localparam logic [2:0] MODE_SPARE = 3'd7;
  localparam int STALL_LIMIT = 300000;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [2:0]               in_mode;
  logic [NODE_W-1:0]        in_node_a;
  logic [NODE_W-1:0]        in_node_b;
  logic [COL_W-1:0]         in_color;
  logic [CFG_W-1:0]         in_real_count;
  logic                     cfg_wr_en;
  logic [CFG_W-1:0]         cfg_wr_data;
  logic                     out_valid;
  logic [DIST_W-1:0]        out_distance;
  logic                     out_reachable;
  logic signed [PRED_W-1:0] out_predecessor;
  int                       fails;
  int                       pending;
  int                       idle_cycles;
  int                       cur_n;

  colored_graph_path_engine_core dut (.*);
  cgpe_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_wr_en || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL colored_graph_path_engine_core");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(logic [2:0] m, int a, int b, int c, int lim);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_node_a <= a;
    in_node_b <= b;
    in_color <= c;
    in_real_count <= lim;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic set_count(int v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_n = (v < MAX_NODES) ? v : MAX_NODES;
    @(posedge clk);
  endtask

  function automatic int node_pick();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, MAX_NODES - 1);
    return $urandom_range(0, cur_n - 1);
  endfunction

  task automatic random_item();
    int r, lim;
    r = $urandom_range(0, 99);
    lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_NODES) : cur_n;
    if (r < 30) send(MODE_CONNECT, node_pick(), node_pick(), 0, 0);
    else if (r < 45) send(MODE_COLOUR, node_pick(), 0, $urandom_range(0, 3), 0);
    else if (r < 65) send(MODE_PATH, node_pick(), node_pick(), $urandom_range(0, 3), lim);
    else if (r < 80) send(MODE_REACH, node_pick(), node_pick(), $urandom_range(0, 3), 0);
    else if (r < 95) send(MODE_PRED, node_pick(), 0, 0, 0);
    else send($urandom_range(0, 7), $urandom_range(0, 127), $urandom_range(0, 127),
              $urandom_range(0, 3), $urandom_range(0, 255));
  endtask

  task automatic random_phase(int count, int items);
    set_count(count);
    for (int i = 0; i < items; i++) begin
      random_item();
      if (i == items / 2) drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_CONNECT;
    in_node_a = '0;
    in_node_b = '0;
    in_color = '0;
    in_real_count = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_cycles = 0;
    cur_n = MAX_NODES;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send(MODE_PRED, 127, 0, 0, 0);
    set_count(8);
    send(MODE_CONNECT, 0, 1, 0, 0);
    send(MODE_CONNECT, 1, 2, 0, 0);
    send(MODE_CONNECT, 2, 7, 0, 0);
    send(MODE_CONNECT, 3, 3, 0, 0);
    send(MODE_CONNECT, 127, 0, 0, 0);
    send(MODE_COLOUR, 1, 0, 2, 0);
    send(MODE_COLOUR, 2, 0, 3, 0);
    send(MODE_COLOUR, 127, 0, 1, 0);
    send(MODE_PATH, 0, 7, 2, 8);
    send(MODE_PRED, 7, 0, 0, 0);
    send(MODE_PATH, 0, 7, 3, 8);
    send(MODE_PATH, 0, 7, 0, 0);
    send(MODE_PATH, 3, 3, 1, 255);
    send(MODE_PATH, 100, 2, 2, 128);
    send(MODE_PATH, 0, 127, 2, 128);
    send(MODE_PRED, 0, 0, 0, 0);
    send(MODE_REACH, 1, 2, 2, 0);
    send(MODE_REACH, 1, 1, 2, 0);
    send(MODE_REACH, 0, 7, 0, 0);
    send(MODE_REACH, 0, 127, 1, 0);
    send(MODE_SPARE, 127, 127, 3, 255);

    random_phase(16, 30);
    random_phase(2, 15);
    random_phase(8, 25);
    random_phase(MAX_NODES, 15);
    random_phase(255, 10);

    drain();
    repeat (300) @(posedge clk);
    if (fails == 0) begin
      $display("PASS colored_graph_path_engine_core");
    end else begin
      $display("FAIL colored_graph_path_engine_core");
    end
    $finish;
  end

endmodule

// ===== colored_graph_path_engine_core.f =====
+incdir+sv
sv/cgpe_pkg.sv
sv/cgpe_mem.sv
sv/cgpe_alu.sv
sv/cgpe_ctrl.sv
sv/colored_graph_path_engine_core.sv
sv/cgpe_chk.sv
sim/cgpe_checker.sv
sim/tb_top.sv
